// File: design/pll_pkg.sv
`timescale 1ns / 1ps

package pll_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int FUNC_W    = 2;
    localparam int POS_W     = 5;
    localparam int DATA_W    = 32;
    localparam int STATUS_W  = 2;

    localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_REPLACE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] new_value;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    found_position;
        logic [POS_W-1:0]    list_length;
    } t_out_item;

    typedef struct packed {
        logic insert;
        logic delete;
        logic replace;
    } t_cell_op;

endpackage

// File: design/pll_cell.sv
`timescale 1ns / 1ps

module pll_cell #(
    parameter int DEPTH = pll_pkg::DEPTH_DEF,
    parameter int IDX   = 0
) (
    input  logic                              i_clk,
    input  pll_pkg::t_cell_op                 i_op,
    input  logic signed [pll_pkg::DATA_W-1:0] i_value,
    input  logic signed [pll_pkg::DATA_W-1:0] i_new_value,
    input  logic [$clog2(DEPTH+1)-1:0]        i_count,
    input  logic [$clog2(DEPTH)-1:0]          i_pos_idx,
    input  logic signed [pll_pkg::DATA_W-1:0] i_prev_entry,
    input  logic signed [pll_pkg::DATA_W-1:0] i_next_entry,
    input  logic                              i_hit,
    output logic                              o_hit,
    output logic                              o_first,
    output logic signed [pll_pkg::DATA_W-1:0] o_entry
);
    import pll_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam logic [CW-1:0] MY_CNT = CW'(IDX);
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic signed [DATA_W-1:0] r_entry;
    logic signed [DATA_W-1:0] n_entry;
    logic                     w_match;

    assign w_match = (MY_CNT < i_count) && (r_entry == i_value);
    assign o_first = w_match && !i_hit;
    assign o_hit   = w_match || i_hit;
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_op.insert) begin
            if (MY_IDX == i_pos_idx) begin
                n_entry = i_value;
            end else if (MY_IDX > i_pos_idx) begin
                n_entry = i_prev_entry;
            end
        end else if (i_op.delete) begin
            if (MY_IDX >= i_pos_idx) begin
                n_entry = i_next_entry;
            end
        end else if (i_op.replace && o_first) begin
            n_entry = i_new_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// File: design/positional_list_engine.sv
`timescale 1ns / 1ps
// Latency: a result is valid in the cycle after its input transfer.
// Throughput: one item per cycle unless output stalls; every operation finishes in the single
// update of the cell row, whose first-match search ripples through the cells within that cycle.
// Reset clears the entry count and the output valid; the stored entries are not cleared.

module positional_list_engine #(
    parameter int DEPTH = pll_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pll_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pll_pkg::t_out_item o_out_data
);
    import pll_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic                     w_accept;
    logic signed [DATA_W-1:0] w_entry [DEPTH];
    logic [DEPTH:0]           w_hit;
    logic [DEPTH-1:0]         w_first;
    logic [CW-1:0]            w_found;
    logic [PW-1:0]            w_found_ext;
    logic [PW-1:0]            w_pos;
    logic [PW-1:0]            w_cnt;
    logic [PW-1:0]            w_len_ext;
    logic [IW-1:0]            w_pos_idx;
    t_cell_op                 w_op;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    t_out_item     r_out_data;
    t_out_item     n_out_data;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_hit[0]   = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_prev;
        logic signed [DATA_W-1:0] w_next;

        if (g == 0) begin : g_first
            assign w_prev = i_in_data.value;
        end else begin : g_mid
            assign w_prev = w_entry[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_next = w_entry[g];
        end else begin : g_inner
            assign w_next = w_entry[g+1];
        end

        pll_cell #(
            .DEPTH(DEPTH),
            .IDX  (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_op        (w_op),
            .i_value     (i_in_data.value),
            .i_new_value (i_in_data.new_value),
            .i_count     (r_count),
            .i_pos_idx   (w_pos_idx),
            .i_prev_entry(w_prev),
            .i_next_entry(w_next),
            .i_hit       (w_hit[g]),
            .o_hit       (w_hit[g+1]),
            .o_first     (w_first[g]),
            .o_entry     (w_entry[g])
        );
    end

    always_comb begin
        w_found = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_first[i]) begin
                w_found = w_found | CW'(i + 1);
            end
        end
    end

    assign w_found_ext = PW'(w_found);
    assign w_pos       = PW'(i_in_data.position);
    assign w_cnt       = PW'(r_count);
    assign w_pos_idx   = IW'(w_pos - PW'(1));
    assign w_len_ext   = PW'(n_count);

    always_comb begin
        w_op                      = '0;
        n_count                   = r_count;
        n_out_data.status         = ST_OK;
        n_out_data.found_position = '0;
        case (i_in_data.func)
            FUNC_INSERT: begin
                if (w_pos == '0 || w_pos > w_cnt + PW'(1)) begin
                    n_out_data.status = ST_BADPOS;
                end else if (r_count == CW'(DEPTH)) begin
                    n_out_data.status = ST_FULL;
                end else begin
                    w_op.insert = w_accept;
                    n_count     = r_count + CW'(1);
                end
            end
            FUNC_DELETE: begin
                if (w_pos == '0 || w_pos > w_cnt) begin
                    n_out_data.status = ST_BADPOS;
                end else begin
                    w_op.delete = w_accept;
                    n_count     = r_count - CW'(1);
                end
            end
            FUNC_SEARCH, FUNC_REPLACE: begin
                n_out_data.found_position = w_found_ext[POS_W-1:0];
                if (!w_hit[DEPTH]) begin
                    n_out_data.status = ST_NOTFOUND;
                end else if (i_in_data.func == FUNC_REPLACE) begin
                    w_op.replace = w_accept;
                end
            end
            default: begin
                n_out_data.status = ST_OK;
            end
        endcase
        n_out_data.list_length = w_len_ext[POS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: design/pll_checker.sv
`timescale 1ns / 1ps

module pll_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input pll_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input pll_pkg::t_out_item o_out_data
);
    import pll_pkg::*;

    // Every accepted item yields a result in the following cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("no result after input transfer");

    // The input side stalls only while a result waits to be taken.
    a_stall_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without a pending result");

    // A search never reports a position or capacity error.
    a_search_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.func == FUNC_SEARCH) |=>
        (o_out_data.status == ST_OK || o_out_data.status == ST_NOTFOUND))
        else $error("search gave an unexpected status");

    // A pending result stays valid until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("pending result dropped or changed");

endmodule

bind positional_list_engine pll_checker u_pll_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .i_in_data  (i_in_data),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);
